// ===== design/gtrav_pkg.sv =====
`timescale 1ns / 1ps
package gtrav_pkg;

  localparam int IdW = 5;

  localparam logic [2:0] ACT_ADD_NODE = 3'd0;
  localparam logic [2:0] ACT_ADD_EDGE = 3'd1;
  localparam logic [2:0] ACT_BFS      = 3'd2;
  localparam logic [2:0] ACT_DFS      = 3'd3;
  localparam logic [2:0] ACT_CLEAR    = 3'd4;

  localparam logic [1:0] ST_VISIT  = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_OVF    = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mark_node;
    logic       mark_edge;
    logic       clear_all;
    logic       status_en;
    logic [1:0] status_val;
    logic       bfs_init;
    logic       dfs_init;
    logic       store_rd;
    logic       edge_append;
    logic       i_inc;
    logic       edge_side2;
    logic       q_rd;
    logic       b_load;
    logic       b_check;
    logic       stk_rd;
    logic       d_load;
    logic       d_adv;
    logic       d_pop;
    logic       d_push;
    logic       emit_resp;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       a_ok;
    logic       b_ok;
    logic       a_present;
    logic       edge_more;
    logic       i_lt_cnt;
    logic       match;
    logic       ovf;
    logic       q_nonempty;
    logic       sp_nonzero;
    logic       dfs_take;
    logic       pend_block;
    logic       out_free;
  } stat_t;

endpackage

// ===== design/gtrav_ctrl.sv =====
`timescale 1ns / 1ps
module gtrav_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 idle_o,
  input  gtrav_pkg::stat_t     stat_i,
  output gtrav_pkg::cmd_t      cmd_o
);
  import gtrav_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RESP   = 4'd2;
  localparam logic [3:0] S_ESCAN  = 4'd3;
  localparam logic [3:0] S_ECMP   = 4'd4;
  localparam logic [3:0] S_ENEXT  = 4'd5;
  localparam logic [3:0] S_BPOP   = 4'd6;
  localparam logic [3:0] S_BLOAD  = 4'd7;
  localparam logic [3:0] S_BSCAN  = 4'd8;
  localparam logic [3:0] S_BCHK   = 4'd9;
  localparam logic [3:0] S_TEND   = 4'd10;
  localparam logic [3:0] S_DTOP   = 4'd11;
  localparam logic [3:0] S_DLOAD  = 4'd12;
  localparam logic [3:0] S_DSCAN  = 4'd13;
  localparam logic [3:0] S_DCHK   = 4'd14;

  logic [3:0] state_q, state_d;

  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.status_en  = 1'b1;
        cmd_o.status_val = ST_DONE;
        state_d          = S_RESP;
        unique case (stat_i.act) inside
          ACT_ADD_NODE: cmd_o.mark_node = stat_i.a_ok;
          ACT_ADD_EDGE: begin
            if (stat_i.a_ok && stat_i.b_ok) begin
              cmd_o.status_en = 1'b0;
              cmd_o.mark_edge = 1'b1;
              state_d         = S_ESCAN;
            end
          end
          ACT_BFS, ACT_DFS: begin
            if (!(stat_i.a_ok && stat_i.a_present)) begin
              cmd_o.status_val = ST_ABSENT;
            end else if (stat_i.act == ACT_BFS) begin
              cmd_o.status_en = 1'b0;
              cmd_o.bfs_init  = 1'b1;
              state_d         = S_BPOP;
            end else begin
              cmd_o.status_en = 1'b0;
              cmd_o.dfs_init  = 1'b1;
              state_d         = S_DSCAN;
            end
          end
          ACT_CLEAR: cmd_o.clear_all = 1'b1;
          default: ;
        endcase
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit_resp = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_ESCAN: begin
        if (stat_i.i_lt_cnt) begin
          cmd_o.store_rd = 1'b1;
          state_d        = S_ECMP;
        end else begin
          cmd_o.edge_append = 1'b1;
          state_d           = S_ENEXT;
        end
      end
      S_ECMP: begin
        if (stat_i.match) begin
          state_d = S_ENEXT;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_ESCAN;
        end
      end
      S_ENEXT: begin
        if (stat_i.edge_more) begin
          cmd_o.edge_side2 = 1'b1;
          state_d          = S_ESCAN;
        end else begin
          cmd_o.status_en  = 1'b1;
          cmd_o.status_val = stat_i.ovf ? ST_OVF : ST_DONE;
          state_d          = S_RESP;
        end
      end
      S_BPOP: begin
        if (stat_i.q_nonempty) begin
          cmd_o.q_rd = 1'b1;
          state_d    = S_BLOAD;
        end else begin
          state_d = S_TEND;
        end
      end
      S_BLOAD: begin
        if (!stat_i.pend_block) begin
          cmd_o.b_load = 1'b1;
          state_d      = S_BSCAN;
        end
      end
      S_BSCAN: begin
        if (stat_i.i_lt_cnt) begin
          cmd_o.store_rd = 1'b1;
          state_d        = S_BCHK;
        end else begin
          state_d = S_BPOP;
        end
      end
      S_BCHK: begin
        cmd_o.b_check = 1'b1;
        state_d       = S_BSCAN;
      end
      S_TEND: begin
        if (stat_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_DTOP: begin
        if (stat_i.sp_nonzero) begin
          cmd_o.stk_rd = 1'b1;
          state_d      = S_DLOAD;
        end else begin
          state_d = S_TEND;
        end
      end
      S_DLOAD: begin
        cmd_o.d_load = 1'b1;
        state_d      = S_DSCAN;
      end
      S_DSCAN: begin
        if (stat_i.i_lt_cnt) begin
          cmd_o.store_rd = 1'b1;
          cmd_o.d_adv    = 1'b1;
          state_d        = S_DCHK;
        end else begin
          cmd_o.d_pop = 1'b1;
          state_d     = S_DTOP;
        end
      end
      S_DCHK: begin
        if (stat_i.dfs_take) begin
          if (!stat_i.pend_block) begin
            cmd_o.d_push = 1'b1;
            state_d      = S_DSCAN;
          end
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_DSCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/gtrav_dp.sv =====
`timescale 1ns / 1ps
module gtrav_dp #(
  parameter int NODE_COUNT = 32,
  parameter int MAX_DEGREE = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [2:0]                action_i,
  input  logic [gtrav_pkg::IdW-1:0] node_a_i,
  input  logic [gtrav_pkg::IdW-1:0] node_b_i,
  input  gtrav_pkg::cmd_t           cmd_i,
  output gtrav_pkg::stat_t          stat_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [gtrav_pkg::IdW-1:0] node_o,
  output logic [1:0]                status_o,
  output logic                      last_o
);
  import gtrav_pkg::*;

  localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int QW = $clog2(NODE_COUNT + 1);
  localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int CW = $clog2(MAX_DEGREE + 1);
  localparam int SD = NODE_COUNT << DW;
  localparam int EW = IdW + CW;
  localparam logic [NODE_COUNT-1:0] NODE_ONE = NODE_COUNT'(1);

  logic [2:0]     act_q;
  logic [IdW-1:0] a_q, b_q, u_q, pend_q, st_rd_q, q_rd_q;
  logic [EW-1:0]  stk_rd_q;
  logic [CW-1:0]  i_q;
  logic           side_q, ovf_q, pend_valid_q;
  logic [1:0]     resp_status_q;
  logic [QW-1:0]  head_q, tail_q, sp_q, sp_m1;
  logic [NODE_COUNT-1:0] present_q, vis_q;
  logic [CW-1:0]  cnt_q [NODE_COUNT];

  logic [IdW-1:0] store_mem [SD];
  logic [IdW-1:0] queue_mem [NODE_COUNT];
  logic [EW-1:0]  stack_mem [NODE_COUNT];

  logic           out_valid_q, out_last_q;
  logic [IdW-1:0] out_node_q;
  logic [1:0]     out_status_q;

  logic [NW-1:0]  a_idx, b_idx, u_idx, v_idx;
  logic [CW-1:0]  cnt_u;
  logic [IdW-1:0] v_edge;
  logic           cnt_full, v_ok, bfs_take, dfs_take, out_free, emit_pend, emit_any;

  assign a_idx    = NW'(a_q);
  assign b_idx    = NW'(b_q);
  assign u_idx    = NW'(u_q);
  assign v_idx    = NW'(st_rd_q);
  assign cnt_u    = cnt_q[u_idx];
  assign v_edge   = side_q ? a_q : b_q;
  assign cnt_full = 32'(cnt_u) >= MAX_DEGREE;
  assign v_ok     = 32'(st_rd_q) < NODE_COUNT;
  assign sp_m1    = sp_q - 1'b1;
  assign bfs_take = v_ok && !vis_q[v_idx] && (32'(tail_q) < NODE_COUNT);
  assign dfs_take = v_ok && !vis_q[v_idx] && (32'(sp_q) < NODE_COUNT);
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_pend = (cmd_i.b_load || cmd_i.d_push) && pend_valid_q;
  assign emit_any  = cmd_i.emit_resp || cmd_i.emit_last || emit_pend;

  always_comb begin
    stat_o            = '0;
    stat_o.act        = act_q;
    stat_o.a_ok       = 32'(a_q) < NODE_COUNT;
    stat_o.b_ok       = 32'(b_q) < NODE_COUNT;
    stat_o.a_present  = present_q[a_idx];
    stat_o.edge_more  = !side_q && (a_q != b_q);
    stat_o.i_lt_cnt   = i_q < cnt_u;
    stat_o.match      = st_rd_q == v_edge;
    stat_o.ovf        = ovf_q;
    stat_o.q_nonempty = head_q < tail_q;
    stat_o.sp_nonzero = sp_q != '0;
    stat_o.dfs_take   = dfs_take;
    stat_o.pend_block = pend_valid_q && !out_free;
    stat_o.out_free   = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      a_q   <= node_a_i;
      b_q   <= node_b_i;
    end
    if (cmd_i.status_en) begin
      resp_status_q <= cmd_i.status_val;
    end
    if (cmd_i.mark_edge || cmd_i.dfs_init) begin
      u_q <= a_q;
      i_q <= '0;
    end else if (cmd_i.edge_side2) begin
      u_q <= b_q;
      i_q <= '0;
    end else if (cmd_i.b_load) begin
      u_q <= q_rd_q;
      i_q <= '0;
    end else if (cmd_i.d_load) begin
      u_q <= stk_rd_q[EW-1:CW];
      i_q <= stk_rd_q[CW-1:0];
    end else if (cmd_i.d_push) begin
      u_q <= st_rd_q;
      i_q <= '0;
    end else if (cmd_i.i_inc || cmd_i.b_check) begin
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.mark_edge) begin
      side_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (cmd_i.edge_side2) begin
      side_q <= 1'b1;
    end else if (cmd_i.edge_append && cnt_full) begin
      ovf_q <= 1'b1;
    end
    if (cmd_i.dfs_init) begin
      pend_q <= a_q;
    end else if (cmd_i.b_load) begin
      pend_q <= q_rd_q;
    end else if (cmd_i.d_push) begin
      pend_q <= st_rd_q;
    end
    if (emit_any) begin
      out_node_q   <= cmd_i.emit_resp ? '0 : pend_q;
      out_status_q <= cmd_i.emit_resp ? resp_status_q : ST_VISIT;
      out_last_q   <= cmd_i.emit_resp || cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_append && !cnt_full) begin
      store_mem[{u_idx, cnt_u[DW-1:0]}] <= v_edge;
    end
    if (cmd_i.store_rd) begin
      st_rd_q <= store_mem[{u_idx, i_q[DW-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bfs_init) begin
      queue_mem[NW'(0)] <= a_q;
    end else if (cmd_i.b_check && bfs_take) begin
      queue_mem[tail_q[NW-1:0]] <= st_rd_q;
    end
    if (cmd_i.q_rd) begin
      q_rd_q <= queue_mem[head_q[NW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dfs_init) begin
      stack_mem[NW'(0)] <= {a_q, CW'(0)};
    end else if (cmd_i.d_adv) begin
      stack_mem[sp_m1[NW-1:0]] <= {u_q, i_q + 1'b1};
    end else if (cmd_i.d_push) begin
      stack_mem[sp_q[NW-1:0]] <= {st_rd_q, CW'(0)};
    end
    if (cmd_i.stk_rd) begin
      stk_rd_q <= stack_mem[sp_m1[NW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      vis_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      sp_q         <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < NODE_COUNT; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      if (cmd_i.mark_node) begin
        present_q[a_idx] <= 1'b1;
      end else if (cmd_i.mark_edge) begin
        present_q <= present_q | (NODE_ONE << a_idx) | (NODE_ONE << b_idx);
      end else if (cmd_i.clear_all) begin
        present_q <= '0;
      end
      if (cmd_i.clear_all) begin
        for (int k = 0; k < NODE_COUNT; k++) begin
          cnt_q[k] <= '0;
        end
      end else if (cmd_i.edge_append && !cnt_full) begin
        cnt_q[u_idx] <= cnt_u + 1'b1;
      end
      if (cmd_i.bfs_init || cmd_i.dfs_init) begin
        vis_q <= NODE_ONE << a_idx;
      end else if ((cmd_i.b_check && bfs_take) || cmd_i.d_push) begin
        vis_q[v_idx] <= 1'b1;
      end
      if (cmd_i.bfs_init) begin
        head_q <= '0;
        tail_q <= QW'(1);
      end else begin
        if (cmd_i.b_load) begin
          head_q <= head_q + 1'b1;
        end
        if (cmd_i.b_check && bfs_take) begin
          tail_q <= tail_q + 1'b1;
        end
      end
      if (cmd_i.dfs_init) begin
        sp_q <= QW'(1);
      end else if (cmd_i.d_push) begin
        sp_q <= sp_q + 1'b1;
      end else if (cmd_i.d_pop) begin
        sp_q <= sp_m1;
      end
      if (cmd_i.bfs_init || cmd_i.emit_last) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.dfs_init || cmd_i.b_load || cmd_i.d_push) begin
        pend_valid_q <= 1'b1;
      end
      if (emit_any) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign node_o      = out_node_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tail_q) <= NODE_COUNT)
    else $error("queue tail beyond node count");
  a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) <= NODE_COUNT)
    else $error("stack pointer beyond node count");
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_any |-> out_free)
    else $error("result written over a stalled transfer");

endmodule

// ===== design/graph_bfs_dfs_traversal.sv =====
`timescale 1ns / 1ps
// add node, clear and unused actions: the result is sent after decode, once the output is free
// add edge: each end's neighbor list is scanned and the other end appended if absent (one end for a self loop)
// traversals: each visited node's neighbor list is read one entry at a time from the neighbor memory
// one input at a time; a new input is taken once the previous one has finished
// reset clears presence, neighbor counts and control; neighbor memory is not cleared
module graph_bfs_dfs_traversal #(
  parameter int NODE_COUNT = 32,
  parameter int MAX_DEGREE = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                action_i,
  input  logic [gtrav_pkg::IdW-1:0] node_a_i,
  input  logic [gtrav_pkg::IdW-1:0] node_b_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [gtrav_pkg::IdW-1:0] node_o,
  output logic [1:0]                status_o,
  output logic                      last_o
);
  import gtrav_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  idle;

  assign in_stall_o = !idle;

  gtrav_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .idle_o     (idle),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gtrav_dp #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .action_i    (action_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .node_o      (node_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
